>>> src/lidar_block_to_range_columns_top_defines.svh
// Assertion macros shared by the range column parser RTL.
// No dependencies; each including module must have clk and rst_n in scope.
`ifndef LIDAR_BLOCK_TO_RANGE_COLUMNS_TOP_DEFINES_SVH
`define LIDAR_BLOCK_TO_RANGE_COLUMNS_TOP_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define LBRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define LBRC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/lbrc_pkg.sv
// Shared types and constants for the lidar block to range column parser.
// No dependencies.
`default_nettype none

package lbrc_pkg;

    // Block layout
    localparam int          POS_W          = 7;
    localparam int          CH_W           = 5;
    localparam logic [6:0]  BLOCK_BYTES    = 7'd100;
    localparam logic [6:0]  AZ_HIGH_POS    = 7'd2;
    localparam logic [6:0]  AZ_LOW_POS     = 7'd3;
    localparam logic [6:0]  FIRST_DIST_POS = 7'd4;
    localparam logic [4:0]  SPLIT_CH       = 5'd16;
    localparam logic [4:0]  LAST_CH        = 5'd31;

    // Image geometry
    localparam int          COLUMN_W    = 10;
    localparam int          COUNT_W     = 11;
    localparam logic [10:0] MAX_COLUMNS = 11'd900;

    // Azimuth in hundredths to whole degrees: (az * 83887) >> 23, exact for 16 bits
    localparam int          DEGREE_W    = 10;
    localparam logic [16:0] DEG_RECIP   = 17'd83887;
    localparam int          DEG_SHIFT   = 23;

    // Configuration register indexes
    localparam logic CFG_MIN_AZIMUTH = 1'b0;
    localparam logic CFG_MAX_AZIMUTH = 1'b1;

    // Output stream widths
    localparam int TDATA_W = 48;

    // Byte role within a 3-byte channel record
    typedef enum logic [1:0] {
        SUB_HIGH = 2'd0,
        SUB_LOW  = 2'd1,
        SUB_SKIP = 2'd2
    } sub_phase_t;

    typedef enum logic {
        KIND_DISTANCE  = 1'b0,
        KIND_FRAME_END = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [COLUMN_W-1:0]  column;
        logic [3:0]           row;
        logic [15:0]          distance;
        logic [COUNT_W-1:0]   frame_columns;
    } result_t;

    // tdata: column, row, distance, frame_columns from bit 0, zero padded
    function automatic logic [TDATA_W-1:0] pack_tdata(input result_t r);
        pack_tdata = {7'd0, r.frame_columns, r.distance, r.row, r.column};
    endfunction

endpackage

`default_nettype wire

>>> src/lbrc_parse.sv
// Block byte parser: tracks the position in a 100-byte block, checks the
// azimuth window, detects frame wrap and forms distance writes. Uses lbrc_pkg.
`default_nettype none

`include "lidar_block_to_range_columns_top_defines.svh"

module lbrc_parse
    import lbrc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         block_start,
    input  wire logic [15:0]  min_azimuth,
    input  wire logic [15:0]  max_azimuth,
    output logic              res_valid,
    output result_t           res
);

    logic [POS_W-1:0]    pos_reg, pos_next, pos_eff;
    sub_phase_t          sub_reg, sub_next, sub_eff;
    logic [CH_W-1:0]     ch_reg, ch_next, ch_eff;
    logic                acc_reg, acc_next, acc_eff;
    logic [7:0]          az_high_reg, az_high_next;
    logic [7:0]          dist_high_reg, dist_high_next;
    logic [DEGREE_W-1:0] prev_deg_reg, prev_deg_next;
    logic [COUNT_W-1:0]  col_reg, col_next, col_bumped;
    logic [15:0]         azimuth;
    logic [32:0]         deg_product;
    logic [DEGREE_W-1:0] degree;
    logic                in_window;

    // Azimuth decode for the low azimuth byte
    assign azimuth     = {az_high_reg, data_byte};
    assign deg_product = {17'd0, azimuth} * {16'd0, DEG_RECIP};
    assign degree      = deg_product[DEG_SHIFT +: DEGREE_W];
    assign in_window   = (azimuth >= min_azimuth) && (azimuth <= max_azimuth);
    assign col_bumped  = (col_reg < MAX_COLUMNS) ? col_reg + 1'b1 : col_reg;

    // block_start restarts the block at byte zero
    assign pos_eff = block_start ? '0 : pos_reg;
    assign sub_eff = block_start ? SUB_HIGH : sub_reg;
    assign ch_eff  = block_start ? '0 : ch_reg;
    assign acc_eff = block_start ? 1'b0 : acc_reg;

    // Next state and result for the accepted byte
    always_comb
    begin
        pos_next       = pos_reg;
        sub_next       = sub_reg;
        ch_next        = ch_reg;
        acc_next       = acc_reg;
        az_high_next   = az_high_reg;
        dist_high_next = dist_high_reg;
        prev_deg_next  = prev_deg_reg;
        col_next       = col_reg;
        res_valid      = 1'b0;
        res            = '0;
        if (accept)
        begin
            pos_next = pos_eff;
            sub_next = sub_eff;
            ch_next  = ch_eff;
            acc_next = acc_eff;
            if (pos_eff < BLOCK_BYTES)
            begin
                pos_next = pos_eff + 1'b1;
                // channel record counters
                if (pos_eff >= FIRST_DIST_POS)
                begin
                    unique case (sub_eff)
                        SUB_HIGH: sub_next = SUB_LOW;
                        SUB_LOW:  sub_next = SUB_SKIP;
                        SUB_SKIP:
                        begin
                            sub_next = SUB_HIGH;
                            ch_next  = ch_eff + 1'b1;
                        end
                        default:  sub_next = SUB_HIGH;
                    endcase
                end
                priority if (pos_eff == AZ_HIGH_POS)
                begin
                    az_high_next = data_byte;
                end
                else if (pos_eff == AZ_LOW_POS)
                begin
                    acc_next = in_window;
                    if (in_window)
                    begin
                        if (degree < prev_deg_reg)
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_FRAME_END;
                            res.frame_columns = col_reg;
                            col_next          = '0;
                        end
                        prev_deg_next = degree;
                    end
                end
                else if (pos_eff >= FIRST_DIST_POS && acc_eff)
                begin
                    unique case (sub_eff)
                        SUB_HIGH:
                        begin
                            dist_high_next = data_byte;
                            if (ch_eff == SPLIT_CH)
                                col_next = col_bumped;
                        end
                        SUB_LOW:
                        begin
                            if (col_reg < MAX_COLUMNS)
                            begin
                                res_valid    = 1'b1;
                                res.kind     = KIND_DISTANCE;
                                res.column   = col_reg[COLUMN_W-1:0];
                                res.row      = ch_eff[3:0];
                                res.distance = {dist_high_reg, data_byte};
                            end
                            if (ch_eff == LAST_CH)
                                col_next = col_bumped;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= BLOCK_BYTES;
            sub_reg       <= SUB_HIGH;
            ch_reg        <= '0;
            acc_reg       <= 1'b0;
            az_high_reg   <= '0;
            dist_high_reg <= '0;
            prev_deg_reg  <= '0;
            col_reg       <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sub_reg       <= sub_next;
            ch_reg        <= ch_next;
            acc_reg       <= acc_next;
            az_high_reg   <= az_high_next;
            dist_high_reg <= dist_high_next;
            prev_deg_reg  <= prev_deg_next;
            col_reg       <= col_next;
        end
    end

    `LBRC_ASSERT(a_pos_range, pos_reg <= BLOCK_BYTES, "byte position beyond block")
    `LBRC_ASSERT(a_col_sat, col_reg <= MAX_COLUMNS, "column index past limit")
    `LBRC_NEVER(a_write_limit, res_valid && res.kind == KIND_DISTANCE && col_reg >= MAX_COLUMNS,
        "distance write at or beyond column limit")

endmodule

`default_nettype wire

>>> src/lidar_block_to_range_columns_top.sv
// Lidar data block parser producing 16-row range image column writes and
// frame-end markers. Top level; uses lbrc_pkg and lbrc_parse.
//
// One byte is taken per cycle while s_tready is high, parsed in one registered
// pass, and any result goes to the output register, or to a one-entry skid
// stage while the output register waits; the skid stage lets input continue
// while a result waits, and only when both are full is s_tready low.
// Configuration writes are always taken (cfg_ready is tied high).
`default_nettype none

`include "lidar_block_to_range_columns_top_defines.svh"

module lidar_block_to_range_columns_top
    import lbrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] data_byte
    input  wire logic               s_tuser,   // [0] block_start
    // output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [9:0] column, [13:10] row,
                                               // [29:14] distance, [40:30] frame_columns
    output logic                    m_tuser,   // [0] kind
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_addr,
    input  wire logic [15:0]        cfg_data
);

    logic [15:0] min_azimuth_reg, max_azimuth_reg;
    logic        accept, pop, res_valid;
    result_t     res;
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_azimuth_reg <= 16'd0;
            max_azimuth_reg <= 16'd36000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_MIN_AZIMUTH: min_azimuth_reg <= cfg_data;
                CFG_MAX_AZIMUTH: max_azimuth_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    lbrc_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata),
        .block_start (s_tuser),
        .min_azimuth (min_azimuth_reg),
        .max_azimuth (max_azimuth_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register with skid stage
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= res;
            else
                out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pack_tdata(out_data_reg);
    assign m_tuser  = out_data_reg.kind;

    `LBRC_ASSERT(a_skid_order, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `LBRC_NEVER(a_no_drop, res_valid && skid_valid_reg, "result produced with skid full")
    `LBRC_ASSERT(a_skid_drain, (skid_valid_reg && m_tready) |=> !skid_valid_reg,
        "skid did not drain on transfer")

endmodule

`default_nettype wire

>>> tb/sv/lbrc_column_checker.sv
// Checker for the lidar block to range column parser: watches the input,
// output and configuration channels, predicts results and compares them.
// Depends on lbrc_pkg for the result layout, codes and block geometry.
`default_nettype none

module lbrc_column_checker
    import lbrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tuser,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic               m_tuser,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic               cfg_addr,
    input  wire logic [15:0]        cfg_data,
    output int                      fail_count,
    output int                      results_pending,
    output int                      writes_seen,
    output int                      frames_seen
);

    localparam logic [15:0] RESET_MAX_AZIMUTH = 16'd36000;
    localparam int          HUNDREDTHS        = 100;
    localparam int          REPORT_LIMIT      = 40;

    // tdata field positions, lowest bit up
    localparam int ROW_LSB  = COLUMN_W;
    localparam int DIST_LSB = ROW_LSB + 4;
    localparam int CNT_LSB  = DIST_LSB + 16;

    // Window registers as last written
    logic [15:0]         win_lo;
    logic [15:0]         win_hi;

    // Parser state
    logic [POS_W-1:0]    byte_pos;
    logic [7:0]          az_high;
    logic [7:0]          dist_high;
    logic [DEGREE_W-1:0] prev_degree;
    logic [COUNT_W-1:0]  col_index;
    logic                block_ok;

    result_t             column_results_due[$];
    int                  n_fail;
    int                  n_write;
    int                  n_frame;

    task automatic report_mismatch(input string what);
        n_fail++;
        if (n_fail <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Column index moves on twice per block in the window and sticks at the limit
    task automatic bump_column();
        if (col_index < MAX_COLUMNS)
            col_index++;
    endtask

    // Advance the parser by one accepted byte; queue any result it makes
    task automatic parse_block_byte(input logic [7:0] b, input logic start);
        logic [POS_W-1:0]    pos;
        logic [15:0]         az;
        logic [DEGREE_W-1:0] degree;
        int                  off;
        logic [CH_W-1:0]     ch;
        sub_phase_t          sub;
        result_t             r;

        if (start)
        begin
            byte_pos = '0;
            block_ok = 1'b0;
        end
        pos = byte_pos;
        if (pos < BLOCK_BYTES)
        begin
            byte_pos = pos + 1'b1;
            if (pos == AZ_HIGH_POS)
            begin
                az_high = b;
            end
            else if (pos == AZ_LOW_POS)
            begin
                az       = {az_high, b};
                block_ok = (az >= win_lo) && (az <= win_hi);
                if (block_ok)
                begin
                    degree = DEGREE_W'(az / HUNDREDTHS);
                    // Azimuth wrapped: close the frame
                    if (degree < prev_degree)
                    begin
                        r               = '0;
                        r.kind          = KIND_FRAME_END;
                        r.frame_columns = col_index;
                        column_results_due.push_back(r);
                        col_index       = '0;
                    end
                    prev_degree = degree;
                end
            end
            else if (pos >= FIRST_DIST_POS && block_ok)
            begin
                off = int'(pos) - int'(FIRST_DIST_POS);
                ch  = CH_W'(off / 3);
                sub = sub_phase_t'(off % 3);
                case (sub)
                    SUB_HIGH:
                    begin
                        dist_high = b;
                        if (ch == SPLIT_CH)
                            bump_column();
                    end
                    SUB_LOW:
                    begin
                        if (col_index < MAX_COLUMNS)
                        begin
                            r          = '0;
                            r.kind     = KIND_DISTANCE;
                            r.column   = col_index[COLUMN_W-1:0];
                            r.row      = ch[3:0];
                            r.distance = {dist_high, b};
                            column_results_due.push_back(r);
                        end
                        if (ch == LAST_CH)
                            bump_column();
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // Compare one output transfer with the oldest prediction
    task automatic check_column_result();
        result_t             want;
        logic [COLUMN_W-1:0] got_col;
        logic [3:0]          got_row;
        logic [15:0]         got_dist;
        logic [COUNT_W-1:0]  got_cnt;

        got_col  = m_tdata[COLUMN_W-1:0];
        got_row  = m_tdata[ROW_LSB +: 4];
        got_dist = m_tdata[DIST_LSB +: 16];
        got_cnt  = m_tdata[CNT_LSB +: COUNT_W];
        if (m_tuser === KIND_FRAME_END)
            n_frame++;
        else
            n_write++;
        if (column_results_due.size() == 0)
        begin
            report_mismatch($sformatf("result with none due: kind %b tdata %h",
                                      m_tuser, m_tdata));
        end
        else
        begin
            want = column_results_due.pop_front();
            if (m_tuser !== want.kind)
                report_mismatch($sformatf("kind %b, want %b", m_tuser, want.kind));
            if (got_col !== want.column)
                report_mismatch($sformatf("column %0d, want %0d", got_col, want.column));
            if (got_row !== want.row)
                report_mismatch($sformatf("row %0d, want %0d", got_row, want.row));
            if (got_dist !== want.distance)
                report_mismatch($sformatf("distance %0d, want %0d", got_dist,
                                          want.distance));
            if (got_cnt !== want.frame_columns)
                report_mismatch($sformatf("frame_columns %0d, want %0d", got_cnt,
                                          want.frame_columns));
        end
    endtask

    // Channel monitor; counters go out registered so readers see settled values
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lo      = '0;
            win_hi      = RESET_MAX_AZIMUTH;
            byte_pos    = BLOCK_BYTES;
            az_high     = '0;
            dist_high   = '0;
            prev_degree = '0;
            col_index   = '0;
            block_ok    = 1'b0;
            column_results_due.delete();
            n_fail      = 0;
            n_write     = 0;
            n_frame     = 0;
            fail_count      <= 0;
            results_pending <= 0;
            writes_seen     <= 0;
            frames_seen     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_column_result();
            // A byte taken on the same edge as a window write sees the old window
            if (s_tvalid && s_tready)
                parse_block_byte(s_tdata, s_tuser);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == CFG_MIN_AZIMUTH)
                    win_lo = cfg_data;
                else
                    win_hi = cfg_data;
            end
            fail_count      <= n_fail;
            results_pending <= column_results_due.size();
            writes_seen     <= n_write;
            frames_seen     <= n_frame;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/lidar_block_to_range_columns_top_test.sv
// Testbench top for the lidar block to range column parser: drives block
// bytes, window writes and output back-pressure, and reports the verdict.
// Depends on lbrc_pkg, lbrc_column_checker and lidar_block_to_range_columns_top.
`default_nettype none

module lidar_block_to_range_columns_top_test;
    import lbrc_pkg::*;

    localparam int MAX_GAP      = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 8;
    localparam int PHASE_BYTES  = 120;
    localparam int NUM_PHASES   = 8;

    // Window settings for the random phases; one is empty, several are a point
    localparam int PHASE_LO[NUM_PHASES] =
        '{9000, 30000, 12345, 65535, 0, 0, 18000, 0};
    localparam int PHASE_HI[NUM_PHASES] =
        '{27000, 100, 12345, 65535, 0, 65535, 36000, 36000};

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_addr;
    logic [15:0]        cfg_data;

    int fail_count;
    int results_pending;
    int writes_seen;
    int frames_seen;

    int bytes_sent;
    int windows_used;
    bit send_idle;
    bit recv_idle;
    bit hold_req;

    lidar_block_to_range_columns_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    lbrc_column_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .writes_seen     (writes_seen),
        .frames_seen     (frames_seen)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One byte transfer, after an optional random gap
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;

        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Bytes with no block start
    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom), 1'b0);
    endtask

    // First len bytes of a block; extreme alternates all-zero and all-one channels
    task automatic send_block(input logic [15:0] az, input int len, input bit extreme);
        logic [7:0] b;

        for (int p = 0; p < len; p++)
        begin
            if (p == AZ_HIGH_POS)
                b = az[15:8];
            else if (p == AZ_LOW_POS)
                b = az[7:0];
            else if (extreme && p >= FIRST_DIST_POS)
                b = (((p - FIRST_DIST_POS) / 3) % 2 != 0) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom);
            send_byte(b, p == 0);
        end
    endtask

    // Mostly whole blocks in the window, some cut short, some stray bytes
    task automatic send_random_block(input int lo, input int hi);
        int          pick;
        logic [15:0] az;

        pick = $urandom_range(0, 9);
        if (lo <= hi && $urandom_range(0, 3) != 0)
            az = 16'($urandom_range(lo, hi));
        else
            az = 16'($urandom);
        if (pick == 0)
            send_noise($urandom_range(1, 6));
        else if (pick == 1)
            send_block(az, $urandom_range(1, int'(BLOCK_BYTES) - 1), 1'b0);
        else
            send_block(az, BLOCK_BYTES, pick == 2);
    endtask

    // Stop offering, wait for every predicted result, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write both window registers back to back
    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
        cfg_valid <= 1'b1;
        cfg_addr  <= CFG_MIN_AZIMUTH;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_addr  <= CFG_MAX_AZIMUTH;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        windows_used++;
    endtask

    // Output side: random stalls, plus one long hold-off when asked
    initial
    begin
        int wait_cycles;

        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_cycles = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_req)
            begin
                hold_req    = 1'b0;
                wait_cycles = wait_cycles + HOLD_CYCLES;
            end
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= CFG_MIN_AZIMUTH;
        cfg_data  <= '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_req  = 1'b0;
        bytes_sent   = 0;
        windows_used = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, on the reset window: stray bytes before any block,
        // window edges, all-zero and all-one distances, bytes past the end,
        // a rejected block, restarts mid-block, and an azimuth wrap
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_block(16'd36000, BLOCK_BYTES, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_block(16'd36001, BLOCK_BYTES, 1'b0);
        send_block(16'd18000, 20, 1'b0);
        send_block(16'd18000, 53, 1'b0);
        send_block(16'd0, BLOCK_BYTES, 1'b1);
        wait_drained();

        // Random phases over several windows and idling mixes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            int phase_start;

            set_window(16'(PHASE_LO[ph]), 16'(PHASE_HI[ph]));
            send_idle = ph[0];
            recv_idle = ph[1];
            if (ph == 2 || ph == 5)
                hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_block(PHASE_LO[ph], PHASE_HI[ph]);
            wait_drained();
        end

        $display("Sent %0d bytes under %0d window settings, with cut blocks and stray bytes",
                 bytes_sent, windows_used);
        $display("Checked %0d distance writes and %0d frame ends", writes_seen, frames_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
